/* src/assert_macros.svh */
// Assertion helpers used by polar_gaussian_generator_unit.
// PGG_ASSERT_NOW: consequent checked in the same cycle as the antecedent.
// PGG_ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PGG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PGG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pgg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgg_pkg
// Shared constants, cell payload types and helpers of the polar Gaussian unit.
// ----------------------------------------------------------------------------
package pgg_pkg;

    localparam int LOG_STEPS  = 32;   // squarings for the log2 fraction
    localparam int DIV_STEPS  = 29;   // quotient bits of v^2 / s (Q.28 plus integer bit)
    localparam int ROOT_STEPS = 32;   // result bits of the 64-bit integer sqrt
    localparam int Q_FRAC     = 28;

    localparam logic [31:0] TWO_LN2_Q31 = 32'hB17217F8;
    localparam logic [31:0] MAG_MAX     = 32'h7FFFFFFF;

    // Item in the log / divide cell chain
    typedef struct packed {
        logic        valid;
        logic [31:0] m;      // Q1.31 mantissa being squared
        logic [31:0] frac;   // log2 fraction bits collected so far
        logic [5:0]  z;      // leading zero count of s
        logic [61:0] s;
        logic [62:0] r1;     // division remainders
        logic [62:0] r2;
        logic [28:0] q1;     // quotients v1^2/s and v2^2/s
        logic [28:0] q2;
        logic        neg1;
        logic        neg2;
    } t_ld;

    typedef struct packed {
        logic [63:0] x;      // radicand, consumed two bits per cell
        logic [33:0] rem;
        logic [31:0] root;
        logic        neg;
    } t_sq_lane;

    // Item in the sqrt cell chain; lane 0 carries v1, lane 1 carries v2
    typedef struct packed {
        logic             valid;
        t_sq_lane [1:0]   lane;
    } t_sq;

    function automatic logic [5:0] lzc62(input logic [61:0] s);
        logic [5:0] z;
        z = '0;
        for (int i = 0; i < 62; i++) begin
            if (s[i]) begin
                z = 6'(61 - i);
            end
        end
        return z;
    endfunction

endpackage

/* src/pgg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgg_front
// Maps the uniform pair to |v|, squares, forms s, rejects, and normalizes s.
// ----------------------------------------------------------------------------
module pgg_front #(
    parameter int IN_FRAC_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [31:0]      i_first_uniform,
    input  logic [31:0]      i_second_uniform,
    output pgg_pkg::t_ld     o_ld
);

    logic        w_ok1, w_ok2;
    logic [31:0] w_t1, w_t2;

    generate
        if (IN_FRAC_BITS < 32) begin : g_narrow
            assign w_ok1 = (i_first_uniform >> IN_FRAC_BITS) == 32'd0;
            assign w_ok2 = (i_second_uniform >> IN_FRAC_BITS) == 32'd0;
            assign w_t1  = i_first_uniform << (32 - IN_FRAC_BITS);
            assign w_t2  = i_second_uniform << (32 - IN_FRAC_BITS);
        end else begin : g_wide
            assign w_ok1 = 1'b1;
            assign w_ok2 = 1'b1;
            assign w_t1  = i_first_uniform >> (IN_FRAC_BITS - 32);
            assign w_t2  = i_second_uniform >> (IN_FRAC_BITS - 32);
        end
    endgenerate

    logic [31:0] w_a1, w_a2;
    assign w_a1 = w_t1[31] ? {1'b0, w_t1[30:0]} : (32'h8000_0000 - w_t1);
    assign w_a2 = w_t2[31] ? {1'b0, w_t2[30:0]} : (32'h8000_0000 - w_t2);

    // stage 1: magnitudes
    logic        r_s1_valid, r_s1_neg1, r_s1_neg2;
    logic [31:0] r_s1_a1, r_s1_a2;
    // stage 2: squares
    logic        r_s2_valid, r_s2_neg1, r_s2_neg2;
    logic [63:0] r_s2_sq1, r_s2_sq2;
    // stage 3: s and rejection
    logic        r_s3_valid, r_s3_neg1, r_s3_neg2;
    logic [61:0] r_s3_s;
    logic [62:0] r_s3_r1, r_s3_r2;
    // stage 4: leading zeros
    logic        r_s4_valid, r_s4_neg1, r_s4_neg2;
    logic [61:0] r_s4_s;
    logic [62:0] r_s4_r1, r_s4_r2;
    logic [5:0]  r_s4_z;
    // stage 5: normalized mantissa
    logic        r_s5_valid;
    pgg_pkg::t_ld r_s5;

    logic [63:0] w_sq1, w_sq2, w_s;
    logic        w_s_ok;
    logic [61:0] w_norm;

    assign w_sq1  = r_s1_a1 * r_s1_a1;
    assign w_sq2  = r_s1_a2 * r_s1_a2;
    assign w_s    = r_s2_sq1 + r_s2_sq2;
    assign w_s_ok = (w_s[63:62] == 2'b00) && (w_s != 64'd0);
    assign w_norm = r_s4_s << r_s4_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid && w_ok1 && w_ok2;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && w_s_ok;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_a1   <= w_a1;
            r_s1_a2   <= w_a2;
            r_s1_neg1 <= ~w_t1[31];
            r_s1_neg2 <= ~w_t2[31];

            r_s2_sq1  <= w_sq1;
            r_s2_sq2  <= w_sq2;
            r_s2_neg1 <= r_s1_neg1;
            r_s2_neg2 <= r_s1_neg2;

            r_s3_s    <= w_s[61:0];
            r_s3_r1   <= r_s2_sq1[62:0];
            r_s3_r2   <= r_s2_sq2[62:0];
            r_s3_neg1 <= r_s2_neg1;
            r_s3_neg2 <= r_s2_neg2;

            r_s4_s    <= r_s3_s;
            r_s4_z    <= pgg_pkg::lzc62(r_s3_s);
            r_s4_r1   <= r_s3_r1;
            r_s4_r2   <= r_s3_r2;
            r_s4_neg1 <= r_s3_neg1;
            r_s4_neg2 <= r_s3_neg2;

            r_s5.valid <= 1'b0;
            r_s5.m     <= w_norm[61:30];
            r_s5.frac  <= 32'd0;
            r_s5.z     <= r_s4_z;
            r_s5.s     <= r_s4_s;
            r_s5.r1    <= r_s4_r1;
            r_s5.r2    <= r_s4_r2;
            r_s5.q1    <= 29'd0;
            r_s5.q2    <= 29'd0;
            r_s5.neg1  <= r_s4_neg1;
            r_s5.neg2  <= r_s4_neg2;
        end
    end

    always_comb begin
        o_ld       = r_s5;
        o_ld.valid = r_s5_valid;
    end

endmodule

/* src/pgg_ld_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgg_ld_cell
// One log2 squaring step; below DIV_STEPS also one restoring divide per lane.
// ----------------------------------------------------------------------------
module pgg_ld_cell #(
    parameter int STEP = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  pgg_pkg::t_ld i_ld,
    output pgg_pkg::t_ld o_ld
);

    logic [63:0]  w_mm;
    logic [32:0]  w_m2;
    logic [62:0]  w_s63, w_r1s, w_r2s;
    logic [28:0]  w_q1s, w_q2s;
    logic         w_ge1, w_ge2;
    pgg_pkg::t_ld n_ld;
    pgg_pkg::t_ld r_ld;
    logic         r_valid;

    assign w_mm  = i_ld.m * i_ld.m;
    assign w_m2  = w_mm[63:31];
    assign w_s63 = {1'b0, i_ld.s};

    generate
        if (STEP == 0) begin : g_first
            assign w_r1s = i_ld.r1;
            assign w_r2s = i_ld.r2;
            assign w_q1s = i_ld.q1;
            assign w_q2s = i_ld.q2;
        end else begin : g_shift
            assign w_r1s = {i_ld.r1[61:0], 1'b0};
            assign w_r2s = {i_ld.r2[61:0], 1'b0};
            assign w_q1s = {i_ld.q1[27:0], 1'b0};
            assign w_q2s = {i_ld.q2[27:0], 1'b0};
        end
    endgenerate

    assign w_ge1 = w_r1s >= w_s63;
    assign w_ge2 = w_r2s >= w_s63;

    always_comb begin
        n_ld      = i_ld;
        n_ld.m    = w_m2[32] ? w_m2[32:1] : w_m2[31:0];
        n_ld.frac = {i_ld.frac[30:0], w_m2[32]};
        if (STEP < pgg_pkg::DIV_STEPS) begin
            n_ld.r1 = w_ge1 ? (w_r1s - w_s63) : w_r1s;
            n_ld.r2 = w_ge2 ? (w_r2s - w_s63) : w_r2s;
            n_ld.q1 = {w_q1s[28:1], w_ge1};
            n_ld.q2 = {w_q2s[28:1], w_ge2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ld.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ld <= n_ld;
        end
    end

    always_comb begin
        o_ld       = r_ld;
        o_ld.valid = r_valid;
    end

endmodule

/* src/pgg_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgg_sqrt_cell
// One digit-by-digit integer square root step (one result bit) for both lanes.
// ----------------------------------------------------------------------------
module pgg_sqrt_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  pgg_pkg::t_sq i_sq,
    output pgg_pkg::t_sq o_sq
);

    pgg_pkg::t_sq n_sq;
    pgg_pkg::t_sq r_sq;
    logic         r_valid;
    logic [35:0]  w_rem4 [2];
    logic [35:0]  w_trial [2];
    logic [1:0]   w_ge;

    always_comb begin
        n_sq = i_sq;
        for (int l = 0; l < 2; l++) begin
            w_rem4[l]  = {i_sq.lane[l].rem, i_sq.lane[l].x[63:62]};
            w_trial[l] = {2'b00, i_sq.lane[l].root, 2'b01};
            w_ge[l]    = w_rem4[l] >= w_trial[l];
            n_sq.lane[l].x    = {i_sq.lane[l].x[61:0], 2'b00};
            n_sq.lane[l].rem  = w_ge[l] ? 34'(w_rem4[l] - w_trial[l]) : w_rem4[l][33:0];
            n_sq.lane[l].root = {i_sq.lane[l].root[30:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_sq.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    always_comb begin
        o_sq       = r_sq;
        o_sq.valid = r_valid;
    end

endmodule

/* src/polar_gaussian_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_gaussian_generator_unit
// Marsaglia polar method: uniform pair in, pair of standard normal deviates out.
// ----------------------------------------------------------------------------
// Usage:
//   Input (i_valid / o_stall) takes one item per unstalled cycle: two unsigned
//   uniform fractions. Output channel (o_valid / i_stall) gives Q5.26 deviates,
//   two items per accepted pair: v2*f first (o_last_of_pair = 0), then v1*f
//   (o_last_of_pair = 1). A rejected pair (s >= 1 or s == 0) gives nothing.
//   Path from input acceptance to the first output item: 5 front stages,
//   32 log/divide cells, 4 product stages, 32 sqrt cells, a rounding stage
//   and the output register.
//   The pipeline takes one input item per cycle while o_stall is low; each
//   surviving pair holds the single output port for two items, so o_stall
//   rises when surviving pairs arrive faster than the port sends them.
//   The whole pipeline advances on one enable; when the output register still
//   holds a pair and the last stage has a result, the enable drops and o_stall
//   rises. Receiver stalls hold the output item steady.
//   Synchronous reset clears all valid bits and the output phase; data registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polar_gaussian_generator_unit #(
    parameter int IN_FRAC_BITS  = 32,
    parameter int OUT_FRAC_BITS = 26
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_first_uniform,
    input  logic [31:0]        i_second_uniform,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_normal_sample,
    output logic               o_last_of_pair
);

    // rounding shift from Q.28 down to the output format
    localparam int SH    = pgg_pkg::Q_FRAC - OUT_FRAC_BITS;
    localparam int MAG_W = 33 + ((SH < 0) ? -SH : 0);

    logic w_en;
    logic w_take;

    // ------------------------------------------------------------------
    // Front end: |v|, squares, s, rejection, normalization
    // ------------------------------------------------------------------
    pgg_pkg::t_ld w_ld [pgg_pkg::LOG_STEPS + 1];

    pgg_front #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_valid          (i_valid),
        .i_first_uniform  (i_first_uniform),
        .i_second_uniform (i_second_uniform),
        .o_ld             (w_ld[0])
    );

    // ------------------------------------------------------------------
    // Cell chain: -log2(s) fraction by repeated squaring, and v^2 / s
    // ------------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < pgg_pkg::LOG_STEPS; g++) begin : g_ld
            pgg_ld_cell #(
                .STEP (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ld    (w_ld[g]),
                .o_ld    (w_ld[g + 1])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // -2 ln s = n * 2ln2, n = (z + 1) - frac in Q.32
    // ------------------------------------------------------------------
    pgg_pkg::t_ld w_ldo;
    logic [5:0]   w_ip;
    logic [31:0]  w_fp;
    logic [37:0]  w_pi;
    logic [63:0]  w_pf;

    assign w_ldo = w_ld[pgg_pkg::LOG_STEPS];
    assign w_ip  = w_ldo.z + 6'(w_ldo.frac == 32'd0);
    assign w_fp  = 32'd0 - w_ldo.frac;
    assign w_pi  = w_ip * pgg_pkg::TWO_LN2_Q31;
    assign w_pf  = w_fp * pgg_pkg::TWO_LN2_Q31;

    logic        r_p1_valid;
    logic [37:0] r_p1_pi;
    logic [63:0] r_p1_pf;
    logic [28:0] r_p1_q [2];
    logic [1:0]  r_p1_neg;

    logic        r_p2_valid;
    logic [35:0] r_p2_l28;
    logic [28:0] r_p2_q [2];
    logic [1:0]  r_p2_neg;

    logic        r_p3_valid;
    logic [46:0] r_p3_ph [2];
    logic [46:0] r_p3_pl [2];
    logic [1:0]  r_p3_neg;

    logic        r_p4_valid;
    pgg_pkg::t_sq r_p4;

    logic [39:0] w_l32;
    assign w_l32 = 40'({r_p1_pi, 1'b0}) + 40'(r_p1_pf[63:31]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= w_ldo.valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_pi  <= w_pi;
            r_p1_pf  <= w_pf;
            r_p1_q[0] <= w_ldo.q1;
            r_p1_q[1] <= w_ldo.q2;
            r_p1_neg <= {w_ldo.neg2, w_ldo.neg1};

            r_p2_l28 <= w_l32[39:4];
            r_p2_q   <= r_p1_q;
            r_p2_neg <= r_p1_neg;

            // q * l28 split into two 29x18 partial products
            for (int l = 0; l < 2; l++) begin
                r_p3_ph[l] <= r_p2_q[l] * r_p2_l28[35:18];
                r_p3_pl[l] <= r_p2_q[l] * r_p2_l28[17:0];
            end
            r_p3_neg <= r_p2_neg;

            r_p4.valid <= 1'b0;
            for (int l = 0; l < 2; l++) begin
                r_p4.lane[l].x    <= 64'({r_p3_ph[l], 18'd0}) + 64'(r_p3_pl[l]);
                r_p4.lane[l].rem  <= 34'd0;
                r_p4.lane[l].root <= 32'd0;
                r_p4.lane[l].neg  <= r_p3_neg[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: floor(sqrt(q * L)), one root bit per cell
    // ------------------------------------------------------------------
    pgg_pkg::t_sq w_sq [pgg_pkg::ROOT_STEPS + 1];

    always_comb begin
        w_sq[0]       = r_p4;
        w_sq[0].valid = r_p4_valid;
    end

    generate
        for (g = 0; g < pgg_pkg::ROOT_STEPS; g++) begin : g_sq
            pgg_sqrt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_sq    (w_sq[g]),
                .o_sq    (w_sq[g + 1])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Round to the output format, saturate, apply sign
    // ------------------------------------------------------------------
    pgg_pkg::t_sq w_sqo;
    logic [MAG_W-1:0] w_mag [2];
    logic [31:0]      w_sat [2];
    logic [31:0]      w_dev [2];

    assign w_sqo = w_sq[pgg_pkg::ROOT_STEPS];

    generate
        for (g = 0; g < 2; g++) begin : g_rnd
            if (SH > 0) begin : g_down
                assign w_mag[g] = MAG_W'(({1'b0, w_sqo.lane[g].root}
                                          + (33'd1 << (SH - 1))) >> SH);
            end else if (SH == 0) begin : g_same
                assign w_mag[g] = MAG_W'(w_sqo.lane[g].root);
            end else begin : g_up
                assign w_mag[g] = MAG_W'(w_sqo.lane[g].root) << (-SH);
            end
            assign w_sat[g] = (w_mag[g] > MAG_W'(pgg_pkg::MAG_MAX)) ? pgg_pkg::MAG_MAX
                                                                    : w_mag[g][31:0];
            assign w_dev[g] = w_sqo.lane[g].neg ? (32'd0 - w_sat[g]) : w_sat[g];
        end
    endgenerate

    logic        r_fin_valid;
    logic [31:0] r_fin_dev [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_en) begin
            r_fin_valid <= w_sqo.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin_dev <= w_dev;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds one pair, sends v2 deviate then v1 deviate
    // ------------------------------------------------------------------
    logic        r_out_full;
    logic        r_out_phase;
    logic [31:0] r_out_first;
    logic [31:0] r_out_second;
    logic        w_out_fire;

    assign w_out_fire = r_out_full && !i_stall;
    assign w_take     = !r_out_full || (w_out_fire && r_out_phase);
    assign w_en       = !r_fin_valid || w_take;
    assign o_stall    = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full  <= 1'b0;
            r_out_phase <= 1'b0;
        end else begin
            if (w_out_fire) begin
                if (r_out_phase) begin
                    r_out_full  <= 1'b0;
                    r_out_phase <= 1'b0;
                end else begin
                    r_out_phase <= 1'b1;
                end
            end
            if (w_en && r_fin_valid) begin
                r_out_full  <= 1'b1;
                r_out_phase <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_fin_valid) begin
            r_out_first  <= r_fin_dev[1];
            r_out_second <= r_fin_dev[0];
        end
    end

    assign o_valid         = r_out_full;
    assign o_last_of_pair  = r_out_phase;
    assign o_normal_sample = r_out_phase ? r_out_second : r_out_first;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PGG_ASSERT_NEXT(a_pair_second, i_clk, i_rst_n, o_valid && !i_stall && !o_last_of_pair, o_valid && o_last_of_pair, "second item of a pair missing")
    `PGG_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, o_valid && r_fin_valid, "input stalled while output can take a pair")
    `PGG_ASSERT_NOW(a_last_after, i_clk, i_rst_n, o_valid && o_last_of_pair, $past(o_valid), "last item without preceding output")

endmodule
